[hw/rtl/sv39pt_pkg.sv]
// sv39pt_pkg: shared types and constants of the sv39 page table engine
// no dependencies; imported by the store, the walker and the top level

package sv39pt_pkg;

    // sequencer states of the walker
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_L1_RD,
        S_L1_CHK,
        S_L2_RD,
        S_L2_CHK,
        S_L3_RD,
        S_L3_CHK,
        S_DONE
    } state_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_NOPAGE = 2'd1,
        STAT_BADPTR = 2'd2
    } status_t;

    // function select of an input item
    localparam logic FUNC_MAP    = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // pte flag bits
    localparam logic [7:0] PTE_V = 8'h01;
    localparam logic [7:0] PTE_U = 8'h10;

    localparam int VA_W    = 39;
    localparam int PA_W    = 56;
    localparam int SIZE_W  = 31;
    localparam int PERM_W  = 8;
    localparam int PTE_W   = 64;
    localparam int PPN_W   = 44;
    localparam int IDX_W   = 9;
    localparam int CNT_W   = SIZE_W - 12;
    localparam int NFP_W   = 9;

    // one input item
    typedef struct packed {
        logic              func;
        logic [VA_W-1:0]   virt_addr;
        logic [PA_W-1:0]   phys_addr;
        logic [SIZE_W-1:0] size_bytes;
        logic [PERM_W-1:0] perm_bits;
    } request_t;

    // one result item
    typedef struct packed {
        logic [PTE_W-1:0] entry;
        status_t          status;
    } result_t;

    // control of one table store access
    typedef struct packed {
        logic             en;
        logic             we;
        logic [PTE_W-1:0] wdata;
    } mem_req_t;

endpackage

[hw/rtl/sv39pt_store.sv]
// sv39pt_store: single-port synchronous memory holding the table pages
// one access per cycle, read data registered; uses sv39pt_pkg

module sv39pt_store
    import sv39pt_pkg::*;
#(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
)
(
    input  logic              clk,
    input  mem_req_t          req,
    input  logic [AW-1:0]     addr,
    output logic [PTE_W-1:0]  rdata
);

    logic [PTE_W-1:0] mem [DEPTH];
    logic [PTE_W-1:0] rdata_reg;

    // read-first access, write when requested
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[addr] <= req.wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/sv39pt_walker.sv]
// sv39pt_walker: sequencer that clears the store, then walks and fills the tables
// drives the table store port; uses sv39pt_pkg

module sv39pt_walker
    import sv39pt_pkg::*;
#(
    parameter int TABLE_PAGES = 16,
    parameter int PW          = 4,
    parameter int AW          = 13
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [PPN_W-1:0]  base_ppn,
    input  logic              in_valid,
    output logic              in_ready,
    input  request_t          in_req,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res,
    output mem_req_t          mem_req,
    output logic [AW-1:0]     mem_addr,
    input  logic [PTE_W-1:0]  mem_rdata
);

    localparam int DEPTH = TABLE_PAGES * 512;
    localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [NFP_W-1:0] PAGES_N   = NFP_W'(TABLE_PAGES);
    localparam logic [PPN_W-1:0] PAGES_P   = PPN_W'(TABLE_PAGES);

    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic                func_reg, func_next;
    logic [VA_W-1:0]     va_reg, va_next;
    logic [PA_W-1:0]     pa_reg, pa_next;
    logic [PERM_W-1:0]   perm_reg, perm_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [PW-1:0]       page_reg, page_next;
    logic [NFP_W-1:0]    nfp_reg, nfp_next;
    logic [PTE_W-1:0]    entry_reg, entry_next;
    status_t             status_reg, status_next;

    logic [SIZE_W-1:0]   size_m1;
    logic [PPN_W:0]      diff;
    logic                rd_valid;
    logic                rd_ok;
    logic [PW-1:0]       rd_page;
    logic [PPN_W:0]      mk_sum;
    logic                mk_ok;
    logic                alloc_ok;
    logic                is_map;
    logic [PTE_W-1:0]    fill_flags;
    logic [PTE_W-1:0]    mk_entry;
    logic [PTE_W-1:0]    leaf_entry;
    logic [AW-1:0]       l1_addr, l2_addr, l3_addr;

    // decode of a stored pointer against the table base
    assign rd_valid = mem_rdata[0];
    assign diff     = {1'b0, mem_rdata[53:10]} - {1'b0, base_ppn};
    assign rd_ok    = !diff[PPN_W] && (diff[PPN_W-1:0] < PAGES_P);
    assign rd_page  = diff[PW-1:0];

    // new pointer from the allocator; it decodes only if base plus page did not wrap
    assign alloc_ok   = nfp_reg < PAGES_N;
    assign mk_sum     = {1'b0, base_ppn} + {{(PPN_W+1-NFP_W){1'b0}}, nfp_reg};
    assign mk_ok      = !mk_sum[PPN_W];
    assign fill_flags = (state_reg == S_L1_CHK) ? {{(PTE_W-PERM_W){1'b0}}, PTE_V}
                      : {{(PTE_W-PERM_W){1'b0}}, perm_reg & (PTE_U | PTE_V)};
    assign mk_entry   = {10'd0, mk_sum[PPN_W-1:0], 10'd0} | fill_flags;
    assign leaf_entry = {10'd0, pa_reg[PA_W-1:12], 2'd0, perm_reg};

    assign is_map  = (func_reg == FUNC_MAP);
    assign size_m1 = in_req.size_bytes - SIZE_W'(1);

    // entry addresses of the three levels
    assign l1_addr = {{PW{1'b0}}, va_reg[38:30]};
    assign l2_addr = {page_reg, va_reg[29:21]};
    assign l3_addr = {page_reg, va_reg[20:12]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_req.func == FUNC_MAP && in_req.size_bytes == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_L1_RD;
                    end
                end
            end
            S_L1_RD:  state_next = S_L1_CHK;
            S_L2_RD:  state_next = S_L2_CHK;
            S_L1_CHK,
            S_L2_CHK:
            begin
                if (rd_valid)
                begin
                    state_next = !rd_ok ? S_DONE
                               : (state_reg == S_L1_CHK) ? S_L2_RD : S_L3_RD;
                end
                else if (!is_map || !alloc_ok || !mk_ok)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = (state_reg == S_L1_CHK) ? S_L2_RD : S_L3_RD;
                end
            end
            S_L3_RD:
            begin
                if (!is_map)
                begin
                    state_next = S_L3_CHK;
                end
                else if (rem_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_L1_RD;
                end
            end
            S_L3_CHK: state_next = S_DONE;
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // store port and handshake outputs
    always_comb
    begin
        mem_req   = '0;
        mem_addr  = l1_addr;
        in_ready  = 1'b0;
        res_valid = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_req.en = 1'b1;
                mem_req.we = 1'b1;
                mem_addr   = clr_reg;
            end
            S_IDLE:   in_ready = 1'b1;
            S_L1_RD:  mem_req.en = 1'b1;
            S_L2_RD:
            begin
                mem_req.en = 1'b1;
                mem_addr   = l2_addr;
            end
            S_L1_CHK,
            S_L2_CHK:
            begin
                mem_addr      = (state_reg == S_L1_CHK) ? l1_addr : l2_addr;
                mem_req.wdata = mk_entry;
                if (!rd_valid && is_map && alloc_ok)
                begin
                    mem_req.en = 1'b1;
                    mem_req.we = 1'b1;
                end
            end
            S_L3_RD:
            begin
                mem_req.en    = 1'b1;
                mem_req.we    = is_map;
                mem_req.wdata = leaf_entry;
                mem_addr      = l3_addr;
            end
            S_DONE:   res_valid = 1'b1;
            default:  mem_req = '0;
        endcase
    end

    // item registers
    always_comb
    begin
        clr_next    = clr_reg;
        func_next   = func_reg;
        va_next     = va_reg;
        pa_next     = pa_reg;
        perm_next   = perm_reg;
        rem_next    = rem_reg;
        page_next   = page_reg;
        nfp_next    = nfp_reg;
        entry_next  = entry_reg;
        status_next = status_reg;
        case (state_reg)
            S_CLEAR:  clr_next = clr_reg + AW'(1);
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next   = in_req.func;
                    va_next     = in_req.virt_addr;
                    pa_next     = in_req.phys_addr;
                    perm_next   = in_req.perm_bits;
                    rem_next    = size_m1[SIZE_W-1:12];
                    entry_next  = '0;
                    status_next = STAT_OK;
                end
            end
            S_L1_CHK,
            S_L2_CHK:
            begin
                if (rd_valid)
                begin
                    if (rd_ok)
                    begin
                        page_next = rd_page;
                    end
                    else
                    begin
                        status_next = STAT_BADPTR;
                    end
                end
                else if (is_map)
                begin
                    if (!alloc_ok)
                    begin
                        status_next = STAT_NOPAGE;
                    end
                    else
                    begin
                        nfp_next = nfp_reg + NFP_W'(1);
                        if (mk_ok)
                        begin
                            page_next = nfp_reg[PW-1:0];
                        end
                        else
                        begin
                            status_next = STAT_BADPTR;
                        end
                    end
                end
            end
            S_L3_RD:
            begin
                if (is_map && rem_reg != '0)
                begin
                    va_next  = va_reg + VA_W'(4096);
                    pa_next  = pa_reg + PA_W'(4096);
                    rem_next = rem_reg - CNT_W'(1);
                end
            end
            S_L3_CHK: entry_next = mem_rdata;
            default:  clr_next = clr_reg;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            nfp_reg   <= NFP_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            nfp_reg   <= nfp_next;
        end
    end

    // payload state
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        va_reg     <= va_next;
        pa_reg     <= pa_next;
        perm_reg   <= perm_next;
        rem_reg    <= rem_next;
        page_reg   <= page_next;
        entry_reg  <= entry_next;
        status_reg <= status_next;
    end

    assign res.entry  = entry_reg;
    assign res.status = status_reg;

endmodule

[hw/rtl/sv39_page_table_map_and_walk_top.sv]
// sv39_page_table_map_and_walk_top: sv39 page table map and walk engine
// holds the table base register and the result register; uses sv39pt_pkg,
// sv39pt_store and sv39pt_walker
//
// usage
//   input stream s_*: one beat is one request; s_tuser[0] selects map (0) or
//   lookup (1). a map writes ((size-1)>>12)+1 leaf entries, creating missing
//   upper-level tables from a bump allocator; a lookup returns the leaf entry.
//   output stream m_*: one beat per request with the entry and a status
//   (ok, out of table pages, pointer outside the store).
//   cfg_*: writes the physical base of table page 0; write only while idle.
// walk sequence
//   each upper table level takes a read and a check/update state on the single
//   store port; the leaf level takes a write (map) or a read and a check (lookup).
//   a map walks all levels again for each page; a zero-size map skips the walk.
//   requests are taken only in the idle state, after the last result is handed over.
// reset and stalls
//   after reset a clearing pass writes zero to all TABLE_PAGES*512 entries, one
//   a cycle; s_tready stays low during it. when m_tready is low the result waits
//   in the output register while the next request is taken and walked; the walker
//   then holds its result until the register frees up.

module sv39_page_table_map_and_walk_top
    import sv39pt_pkg::*;
#(
    parameter int TABLE_PAGES = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // virt_addr[38:0], phys_addr[94:39], size_bytes[125:95], perm_bits[133:126]
    input  logic [135:0]  s_tdata,
    // func[0]
    input  logic [0:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // entry[63:0], status[65:64]
    output logic [71:0]   m_tdata,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [55:0]   cfg_data
);

    localparam int PW    = $clog2(TABLE_PAGES);
    localparam int AW    = PW + IDX_W;
    localparam int DEPTH = TABLE_PAGES * 512;

    logic [PA_W-1:0]  base_reg;
    request_t         in_req;
    result_t          res;
    logic             res_valid;
    logic             res_ready;
    mem_req_t         mem_req;
    logic [AW-1:0]    mem_addr;
    logic [PTE_W-1:0] mem_rdata;
    logic             out_valid_reg;
    result_t          out_reg;

    // unpack the request beat
    assign in_req.func       = s_tuser[0];
    assign in_req.virt_addr  = s_tdata[38:0];
    assign in_req.phys_addr  = s_tdata[94:39];
    assign in_req.size_bytes = s_tdata[125:95];
    assign in_req.perm_bits  = s_tdata[133:126];

    // table base register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= PA_W'(64'h8000_0000);
        end
        else if (cfg_valid && cfg_ready)
        begin
            base_reg <= cfg_data;
        end
    end

    sv39pt_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .req   (mem_req),
        .addr  (mem_addr),
        .rdata (mem_rdata)
    );

    sv39pt_walker #(
        .TABLE_PAGES (TABLE_PAGES),
        .PW          (PW),
        .AW          (AW)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .base_ppn  (base_reg[PA_W-1:12]),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .mem_addr  (mem_addr),
        .mem_rdata (mem_rdata)
    );

    // result register between the walker and the output stream
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.status, out_reg.entry};

endmodule
